// ===== rtl/mic_envelope_follower_top_defines.svh =====
// mic_envelope_follower_top_defines.svh: assertion macros for the envelope follower.
// Included by the files that carry concurrent checks. No other dependencies.
`ifndef MIC_ENVELOPE_FOLLOWER_TOP_DEFINES_SVH
`define MIC_ENVELOPE_FOLLOWER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define MEF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
// Checked at every edge, reset included.
`define MEF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error(msg);
`else
`define MEF_ASSERT(lbl, clk, rst_n, prop, msg)
`define MEF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/mef_pkg.sv =====
// mef_pkg.sv: widths, fixed-point constants, register indexes and FSM states
// of the microphone envelope follower. No dependencies.
`default_nettype none

package mef_pkg;

  // converter width and full-scale code
  localparam int unsigned SAMPLE_BITS = 10;
  localparam logic [SAMPLE_BITS-1:0] MAXV = '1;

  localparam int unsigned STAMP_W = 32;
  localparam int unsigned X_W     = 17;   // Q1.16 normalized sample
  localparam int unsigned BIAS_W  = 25;   // Q1.24
  localparam int unsigned ENV_W   = 16;   // Q1.15
  localparam int unsigned GAIN_W  = 12;   // Q4.8
  localparam int unsigned RATE_W  = 16;   // Q0.16
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned GAIN_FRAC = 8;  // gain fraction bits
  localparam int unsigned ENV_SHIFT = 9;  // Q1.24 -> Q1.15

  localparam int unsigned ACC_W  = BIAS_W + RATE_W;
  localparam int unsigned PROD_W = ACC_W - GAIN_FRAC;

  // long division of (sample << 16) by MAXV, one quotient bit per cycle
  localparam int unsigned DIV_STEPS = SAMPLE_BITS + 16;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [BIAS_W-1:0] ONE_Q24  = BIAS_W'(1) << 24;
  localparam logic [BIAS_W-1:0] HALF_Q24 = BIAS_W'(1) << 23;
  localparam logic [ENV_W-1:0]  ONE_Q15  = ENV_W'(1) << 15;

  localparam logic [GAIN_W-1:0] GAIN_RST  = GAIN_W'(896);
  localparam logic [RATE_W-1:0] BRATE_RST = RATE_W'(39);
  localparam logic [RATE_W-1:0] ERATE_RST = RATE_W'(7864);
  localparam logic [ENV_W-1:0]  FLOOR_RST = ENV_W'(328);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENV_RATE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR     = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_BIAS,
    ST_MUL_BIAS,
    ST_BIAS_UPD,
    ST_SWING,
    ST_MUL_GAIN,
    ST_CLAMP,
    ST_MUL_ENV,
    ST_ENV_UPD,
    ST_OUT
  } mef_state_e;

endpackage

`default_nettype wire

// ===== rtl/mef_if.sv =====
// mef_if.sv: valid/ready stream interfaces for sample input and envelope output.
// Depends on mef_pkg.
`default_nettype none

interface mef_in_if import mef_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [SAMPLE_BITS-1:0] sample;
  logic [STAMP_W-1:0]     timestamp;

  modport source (output valid, output mode, output sample, output timestamp,
                  input ready);
  modport sink   (input valid, input mode, input sample, input timestamp,
                  output ready);
endinterface

interface mef_out_if import mef_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ENV_W-1:0]   envelope;
  logic [STAMP_W-1:0] stamp;

  modport source (output valid, output envelope, output stamp, input ready);
  modport sink   (input valid, input envelope, input stamp, output ready);
endinterface

`default_nettype wire

// ===== rtl/mic_envelope_follower_top.sv =====
// mic_envelope_follower_top.sv: AC-coupled envelope follower, bit-serial datapath.
// Depends on mef_pkg, mef_if.sv and mic_envelope_follower_top_defines.svh.
//
//   channel   dir   transfer carries                 notes
//   smp_i     in    mode, sample, timestamp          taken only when idle
//   env_o     out   envelope, stamp                  one per normal sample
//   cfg       in    cfg_we_i, cfg_idx_i, cfg_data_i  write only, no wait
//
// A sample is normalized by a bit-serial long division; a warm-up sample then
// updates the bias and ends, while a normal sample goes through the shared
// shift-add multiplier (16, 12 and 16 steps) for the bias, gain and envelope.
// Reset: asynchronous, active low; bias returns to 0.5, envelope to zero.
// Stalls: the result sits in an output register, so the block takes the next
// sample while it waits; a second result waits in ST_OUT until the slot frees.
`default_nettype none
`include "mic_envelope_follower_top_defines.svh"

module mic_envelope_follower_top import mef_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  mef_in_if.sink                    smp_i,
  mef_out_if.source                 env_o
);

  // configuration registers
  logic [GAIN_W-1:0] gain_q;
  logic [RATE_W-1:0] bias_rate_q, env_rate_q;
  logic [ENV_W-1:0]  noise_floor_q;

  // control
  mef_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  // filter state
  logic [BIAS_W-1:0] bias_q, bias_d;
  logic [ENV_W-1:0]  env_q, env_d;

  // per-item payload and serial datapath
  logic                   mode_q, mode_d;
  logic [STAMP_W-1:0]     stamp_q, stamp_d;
  logic [SAMPLE_BITS-1:0] num_q, num_d;     // dividend bits, MSB first
  logic [SAMPLE_BITS-1:0] rem_q, rem_d;     // remainder, always below MAXV
  logic [X_W-1:0]         x_q, x_d;         // quotient shifts in here
  logic [ACC_W-1:0]       acc_q, acc_d;
  logic [BIAS_W-1:0]      mcand_q, mcand_d;
  logic [RATE_W-1:0]      mplier_q, mplier_d;
  logic                   neg_q, neg_d;
  logic [ENV_W-1:0]       out_env_q, out_env_d;
  logic [STAMP_W-1:0]     out_stamp_q, out_stamp_d;

  // combinational helpers
  logic                   in_xfer, out_load, cnt_last, mul_step;
  logic [SAMPLE_BITS:0]   rem_sh;
  logic                   q_bit;
  logic [BIAS_W-1:0]      x24;
  logic [BIAS_W:0]        d1_pos, d1_neg;
  logic                   d1_sign;
  logic [BIAS_W-1:0]      d1_mag;
  logic [PROD_W-1:0]      prod;
  logic [ENV_W-1:0]       target;
  logic [ENV_W:0]         d2_pos, d2_neg;
  logic                   d2_sign;
  logic [ENV_W-1:0]       d2_mag;
  logic [BIAS_W-1:0]      bias_step;
  logic [ENV_W-1:0]       env_step, env_new;

  // ---------------------------------------------------------------------------
  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q        <= GAIN_RST;
      bias_rate_q   <= BRATE_RST;
      env_rate_q    <= ERATE_RST;
      noise_floor_q <= FLOOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GAIN:      gain_q        <= cfg_data_i[GAIN_W-1:0];
        CFG_BIAS_RATE: bias_rate_q   <= cfg_data_i[RATE_W-1:0];
        CFG_ENV_RATE:  env_rate_q    <= cfg_data_i[RATE_W-1:0];
        CFG_FLOOR:     noise_floor_q <= cfg_data_i[ENV_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // shared arithmetic
  assign cnt_last = (cnt_q == CNT_W'(1));
  assign in_xfer  = smp_i.valid && smp_i.ready;
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || env_o.ready);
  assign mul_step = state_q inside {ST_MUL_BIAS, ST_MUL_GAIN, ST_MUL_ENV};

  // restoring division step
  assign rem_sh = {rem_q, num_q[SAMPLE_BITS-1]};
  assign q_bit  = (rem_sh >= {1'b0, MAXV});

  // x - bias in Q1.24, as sign and magnitude
  assign x24     = {x_q, 8'b0};
  assign d1_pos  = {1'b0, x24} - {1'b0, bias_q};
  assign d1_neg  = {1'b0, bias_q} - {1'b0, x24};
  assign d1_sign = d1_pos[BIAS_W];
  assign d1_mag  = d1_sign ? d1_neg[BIAS_W-1:0] : d1_pos[BIAS_W-1:0];

  // swing*gain >> 8, saturated at 1.0, then Q1.15
  assign prod   = acc_q[ACC_W-1:GAIN_FRAC];
  assign target = (prod > PROD_W'(ONE_Q24)) ? ONE_Q15
                                            : acc_q[GAIN_FRAC+ENV_SHIFT +: ENV_W];
  assign d2_pos  = {1'b0, target} - {1'b0, env_q};
  assign d2_neg  = {1'b0, env_q} - {1'b0, target};
  assign d2_sign = d2_pos[ENV_W];
  assign d2_mag  = d2_sign ? d2_neg[ENV_W-1:0] : d2_pos[ENV_W-1:0];

  // scaled steps truncate toward zero: magnitude is floored, then signed
  assign bias_step = acc_q[RATE_W +: BIAS_W];
  assign env_step  = acc_q[RATE_W +: ENV_W];
  assign env_new   = neg_q ? (env_q - env_step) : (env_q + env_step);

  // ---------------------------------------------------------------------------
  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_xfer) state_d = ST_DIV;
      ST_DIV:      if (cnt_last) state_d = ST_BIAS;
      ST_BIAS:     state_d = mode_q ? ST_MUL_BIAS : ST_IDLE;
      ST_MUL_BIAS: if (cnt_last) state_d = ST_BIAS_UPD;
      ST_BIAS_UPD: state_d = ST_SWING;
      ST_SWING:    state_d = ST_MUL_GAIN;
      ST_MUL_GAIN: if (cnt_last) state_d = ST_CLAMP;
      ST_CLAMP:    state_d = ST_MUL_ENV;
      ST_MUL_ENV:  if (cnt_last) state_d = ST_ENV_UPD;
      ST_ENV_UPD:  state_d = ST_OUT;
      ST_OUT:      if (out_load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // outputs and datapath
  always_comb begin
    smp_i.ready = (state_q == ST_IDLE);
    cnt_d       = cnt_q;
    bias_d      = bias_q;
    env_d       = env_q;
    mode_d      = mode_q;
    stamp_d     = stamp_q;
    num_d       = num_q;
    rem_d       = rem_q;
    x_d         = x_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    neg_d       = neg_q;
    out_env_d   = out_env_q;
    out_stamp_d = out_stamp_q;
    out_valid_d = env_o.ready ? 1'b0 : out_valid_q;

    // one shift-add step, multiplier bits taken MSB first
    if (mul_step) begin
      acc_d    = {acc_q[ACC_W-2:0], 1'b0} +
                 (mplier_q[RATE_W-1] ? ACC_W'(mcand_q) : '0);
      mplier_d = {mplier_q[RATE_W-2:0], 1'b0};
      cnt_d    = cnt_q - CNT_W'(1);
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          mode_d  = smp_i.mode;
          stamp_d = smp_i.timestamp;
          num_d   = smp_i.sample;
          rem_d   = '0;
          x_d     = '0;
          cnt_d   = CNT_W'(DIV_STEPS);
        end
      end
      ST_DIV: begin
        num_d = {num_q[SAMPLE_BITS-2:0], 1'b0};
        rem_d = q_bit ? SAMPLE_BITS'(rem_sh - {1'b0, MAXV}) : rem_sh[SAMPLE_BITS-1:0];
        x_d   = {x_q[X_W-2:0], q_bit};
        cnt_d = cnt_q - CNT_W'(1);
      end
      ST_BIAS: begin
        if (!mode_q) begin
          // warm-up: bias += (x - bias)/4
          bias_d = d1_sign ? (bias_q - (d1_mag >> 2)) : (bias_q + (d1_mag >> 2));
        end else begin
          acc_d    = '0;
          mcand_d  = d1_mag;
          mplier_d = bias_rate_q;
          neg_d    = d1_sign;
          cnt_d    = CNT_W'(RATE_W);
        end
      end
      ST_BIAS_UPD: begin
        bias_d = neg_q ? (bias_q - bias_step) : (bias_q + bias_step);
      end
      ST_SWING: begin
        acc_d    = '0;
        mcand_d  = d1_mag;
        mplier_d = {gain_q, {(RATE_W-GAIN_W){1'b0}}};
        cnt_d    = CNT_W'(GAIN_W);
      end
      ST_CLAMP: begin
        acc_d    = '0;
        mcand_d  = BIAS_W'(d2_mag);
        mplier_d = env_rate_q;
        neg_d    = d2_sign;
        cnt_d    = CNT_W'(RATE_W);
      end
      ST_ENV_UPD: begin
        env_d = (env_new < noise_floor_q) ? '0 : env_new;
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_env_d   = env_q;
          out_stamp_d = stamp_q;
        end
      end
      default: ;
    endcase
  end

  assign env_o.valid    = out_valid_q;
  assign env_o.envelope = out_env_q;
  assign env_o.stamp    = out_stamp_q;

  // ---------------------------------------------------------------------------
  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      bias_q      <= HALF_Q24;
      env_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      bias_q      <= bias_d;
      env_q       <= env_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    stamp_q     <= stamp_d;
    num_q       <= num_d;
    rem_q       <= rem_d;
    x_q         <= x_d;
    acc_q       <= acc_d;
    mcand_q     <= mcand_d;
    mplier_q    <= mplier_d;
    neg_q       <= neg_d;
    out_env_q   <= out_env_d;
    out_stamp_q <= out_stamp_d;
  end

  // ---------------------------------------------------------------------------
  // checks
  `MEF_ASSERT_ALWAYS(a_bias_range, clk_i, bias_q <= ONE_Q24, "bias left 0..1")
  `MEF_ASSERT_ALWAYS(a_env_range, clk_i, env_q <= ONE_Q15, "envelope above 1.0")
  `MEF_ASSERT(a_warmup_silent, clk_i, rst_ni,
    (state_q == ST_BIAS && !mode_q) |=> (state_q == ST_IDLE),
    "warm-up did not return to idle")
  `MEF_ASSERT(a_floor, clk_i, rst_ni,
    (state_q == ST_ENV_UPD) |=> (env_q == '0 || env_q >= noise_floor_q),
    "envelope below floor kept")
  `MEF_ASSERT(a_result_src, clk_i, rst_ni,
    $rose(out_valid_q) |-> $past(state_q == ST_OUT),
    "result loaded outside ST_OUT")

endmodule

`default_nettype wire
